// ===== rtl/core/afas_pkg.sv =====
`default_nettype none
package afas_pkg;

  // Default parameter values
  localparam int SETTLE_TICKS_DEF = 20;
  localparam int SCAN_PERIOD_DEF  = 160;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_INV_MASS  = 3'd0;
  localparam logic [2:0] REG_DAMPING   = 3'd1;
  localparam logic [2:0] REG_TARGET_F  = 3'd2;
  localparam logic [2:0] REG_ADAPT     = 3'd3;
  localparam logic [2:0] REG_TIME_STEP = 3'd4;
  localparam logic [2:0] REG_SETTLE    = 3'd5;
  localparam logic [2:0] REG_SCAN_SPD  = 3'd6;
  localparam logic [2:0] REG_VEL_LIM   = 3'd7;

  // Register reset values
  localparam logic [16:0] INV_MASS_RST  = 17'd4369;
  localparam logic [20:0] DAMPING_RST   = 21'd65536;
  localparam logic [31:0] TARGET_F_RST  = 32'd655360;
  localparam logic [16:0] ADAPT_RST     = 17'd66;
  localparam logic [16:0] TIME_STEP_RST = 17'd2621;
  localparam logic [30:0] SETTLE_RST    = 31'd3277;
  localparam logic [16:0] SCAN_SPD_RST  = 17'd3277;
  localparam logic [16:0] VEL_LIM_RST   = 17'd16384;

  // Raw Q16 magnitude below which a command is forced to zero
  localparam logic signed [43:0] DEADBAND_RAW = 44'sd7;

  // Division: two quotient bits per cycle over a 52-bit dividend
  localparam int DIV_W     = 52;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_BV,
    ST_MUL_BPHI,
    ST_MUL_SGP,
    ST_DRN1,
    ST_RND1,
    ST_MUL_IML,
    ST_MUL_IMH,
    ST_DRN2,
    ST_RND2,
    ST_MUL_DTL,
    ST_MUL_DTH,
    ST_DRN3,
    ST_RND3,
    ST_MUL_INT,
    ST_DRN4,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN
  } state_e;

  // What to do next cycle with the registered product
  typedef struct packed {
    logic valid;
    logic sub;
    logic shift;
  } pend_t;

  typedef struct packed {
    logic signed [33:0] mul_a;
    logic signed [21:0] mul_b;
    pend_t              pend;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/adaptive_force_admittance_step_unit.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------------------
// s        | in        | s_tvalid / s_tready    | s_tdata: measured_force, measured_velocity
// m        | out       | m_tvalid / m_tready    | m_tdata: command_vel_z, command_vel_y; m_tuser
// apb      | in        | psel, penable, pready  | 8 registers at byte address 4*i
//
// An item is worked on in sequence through the single shared 34x22 multiplier; when the damping
// is non-zero the integrator update also runs the radix-4 restoring divider, which delivers two
// quotient bits a cycle, and when it is zero these steps are skipped. Reset (asynchronous,
// active low) returns the sequencer to idle, clears the controller state and loads the register
// defaults. A stalled output holds only the finished item: the next item is accepted and worked
// on, and it waits at the last step until the output frees.
`default_nettype none
module adaptive_force_admittance_step_unit #(
  parameter int SETTLE_TICKS = afas_pkg::SETTLE_TICKS_DEF,
  parameter int SCAN_PERIOD  = afas_pkg::SCAN_PERIOD_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] measured_force, [63:32] measured_velocity
  // Result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [17:0] command_vel_z, [35:18] command_vel_y, zeros
  output logic             m_tuser,   // [0] scanning
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Counter widths follow the parameters.
  localparam int CNT_W     = $clog2(SETTLE_TICKS + 2);
  localparam int PH_W      = $clog2(SCAN_PERIOD);
  localparam int UP_END    = (SCAN_PERIOD * 3) / 8;
  localparam int HOLD_END  = SCAN_PERIOD / 2;
  localparam int DOWN_END  = (SCAN_PERIOD * 7) / 8;

  // Configuration registers
  logic        [16:0] inv_mass_q;
  logic        [20:0] damping_q;
  logic signed [31:0] target_f_q;
  logic        [16:0] adapt_q;
  logic        [16:0] time_step_q;
  logic        [30:0] settle_q;
  logic        [16:0] scan_spd_q;
  logic        [16:0] vel_lim_q;

  // Sequencer and datapath
  afas_pkg::state_e   state_q, state_d;
  afas_pkg::ctrl_t    ctrl;
  afas_pkg::pend_t    pend_q;
  logic signed [31:0] force_q;
  logic signed [31:0] vel_q;
  logic signed [31:0] fprev_q;
  logic signed [31:0] phi_q;
  logic signed [59:0] acc_q;
  logic signed [55:0] prod_q;
  logic signed [43:0] r_q;
  logic        [20:0] rem_q;
  logic               neg_q;
  logic [afas_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PH_W-1:0]    phase_q;

  // Output register
  logic               m_valid_q;
  logic [17:0]        vz_out_q;
  logic [17:0]        vy_out_q;
  logic               scan_out_q;

  logic               cfg_wr;
  logic               accept;
  logic               fin_load;
  logic signed [32:0] err_in;
  logic signed [59:0] addend;
  logic signed [59:0] acc_sum;
  logic signed [59:0] acc_rnd;
  logic        [20:0] rem_t;
  logic [afas_pkg::DIV_W-1:0] quo_t;
  logic        [21:0] trial;

  // Values formed in the final step
  logic signed [32:0] err_fin;
  logic        [32:0] err_mag;
  logic signed [53:0] q_signed;
  logic signed [53:0] phi_sum;
  logic signed [31:0] phi_new;
  logic [CNT_W-1:0]   cnt_new;
  logic               scanning;
  logic signed [43:0] vy_raw;
  logic [PH_W-1:0]    phase_new;

  // Deadband to zero, then a symmetric clamp to the limit.
  function automatic logic [17:0] limit_vel(input logic signed [43:0] x,
                                            input logic [16:0] lim);
    logic signed [43:0] y;
    logic signed [43:0] limw;
    y    = x;
    limw = $signed({27'd0, lim});
    if (x > -afas_pkg::DEADBAND_RAW && x < afas_pkg::DEADBAND_RAW) begin
      y = '0;
    end
    if (y > limw) begin
      y = limw;
    end else if (y < -limw) begin
      y = -limw;
    end
    return y[17:0];
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state_q == afas_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fin_load = (state_q == afas_pkg::ST_FIN) && (!m_valid_q || m_tready);

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {4'd0, vy_out_q, vz_out_q};
  assign m_tuser  = scan_out_q;

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      afas_pkg::REG_INV_MASS:  prdata = {15'd0, inv_mass_q};
      afas_pkg::REG_DAMPING:   prdata = {11'd0, damping_q};
      afas_pkg::REG_TARGET_F:  prdata = target_f_q;
      afas_pkg::REG_ADAPT:     prdata = {15'd0, adapt_q};
      afas_pkg::REG_TIME_STEP: prdata = {15'd0, time_step_q};
      afas_pkg::REG_SETTLE:    prdata = {1'b0, settle_q};
      afas_pkg::REG_SCAN_SPD:  prdata = {15'd0, scan_spd_q};
      afas_pkg::REG_VEL_LIM:   prdata = {15'd0, vel_lim_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q  <= afas_pkg::INV_MASS_RST;
      damping_q   <= afas_pkg::DAMPING_RST;
      target_f_q  <= afas_pkg::TARGET_F_RST;
      adapt_q     <= afas_pkg::ADAPT_RST;
      time_step_q <= afas_pkg::TIME_STEP_RST;
      settle_q    <= afas_pkg::SETTLE_RST;
      scan_spd_q  <= afas_pkg::SCAN_SPD_RST;
      vel_lim_q   <= afas_pkg::VEL_LIM_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        afas_pkg::REG_INV_MASS:  inv_mass_q  <= pwdata[16:0];
        afas_pkg::REG_DAMPING:   damping_q   <= pwdata[20:0];
        afas_pkg::REG_TARGET_F:  target_f_q  <= pwdata;
        afas_pkg::REG_ADAPT:     adapt_q     <= pwdata[16:0];
        afas_pkg::REG_TIME_STEP: time_step_q <= pwdata[16:0];
        afas_pkg::REG_SETTLE:    settle_q    <= pwdata[30:0];
        afas_pkg::REG_SCAN_SPD:  scan_spd_q  <= pwdata[16:0];
        afas_pkg::REG_VEL_LIM:   vel_lim_q   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      afas_pkg::ST_IDLE:     if (accept) state_d = afas_pkg::ST_MUL_BV;
      afas_pkg::ST_MUL_BV:   state_d = afas_pkg::ST_MUL_BPHI;
      afas_pkg::ST_MUL_BPHI: state_d = afas_pkg::ST_MUL_SGP;
      afas_pkg::ST_MUL_SGP:  state_d = afas_pkg::ST_DRN1;
      afas_pkg::ST_DRN1:     state_d = afas_pkg::ST_RND1;
      afas_pkg::ST_RND1:     state_d = afas_pkg::ST_MUL_IML;
      afas_pkg::ST_MUL_IML:  state_d = afas_pkg::ST_MUL_IMH;
      afas_pkg::ST_MUL_IMH:  state_d = afas_pkg::ST_DRN2;
      afas_pkg::ST_DRN2:     state_d = afas_pkg::ST_RND2;
      afas_pkg::ST_RND2:     state_d = afas_pkg::ST_MUL_DTL;
      afas_pkg::ST_MUL_DTL:  state_d = afas_pkg::ST_MUL_DTH;
      afas_pkg::ST_MUL_DTH:  state_d = afas_pkg::ST_DRN3;
      afas_pkg::ST_DRN3:     state_d = afas_pkg::ST_RND3;
      afas_pkg::ST_RND3: begin
        if (damping_q == '0) begin
          state_d = afas_pkg::ST_FIN;
        end else begin
          state_d = afas_pkg::ST_MUL_INT;
        end
      end
      afas_pkg::ST_MUL_INT:  state_d = afas_pkg::ST_DRN4;
      afas_pkg::ST_DRN4:     state_d = afas_pkg::ST_DIV_INIT;
      afas_pkg::ST_DIV_INIT: state_d = afas_pkg::ST_DIV;
      afas_pkg::ST_DIV: begin
        if (div_cnt_q == afas_pkg::DIV_CNT_W'(afas_pkg::DIV_STEPS - 1)) begin
          state_d = afas_pkg::ST_FIN;
        end
      end
      afas_pkg::ST_FIN:      if (fin_load) state_d = afas_pkg::ST_IDLE;
      default:               state_d = afas_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: multiplier operands and what happens to the product.
  // The wide operands are split into a 20-bit unsigned low part and a signed high part.
  always_comb begin
    ctrl       = '0;
    case (state_q)
      afas_pkg::ST_MUL_BV: begin
        ctrl.mul_a = {{2{vel_q[31]}}, vel_q};
        ctrl.mul_b = $signed({1'b0, damping_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b1, shift: 1'b0};
      end
      afas_pkg::ST_MUL_BPHI: begin
        ctrl.mul_a = {{2{phi_q[31]}}, phi_q};
        ctrl.mul_b = $signed({1'b0, damping_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b1, shift: 1'b0};
      end
      afas_pkg::ST_MUL_SGP: begin
        ctrl.mul_a = {target_f_q[31], target_f_q[31], target_f_q}
                   - {fprev_q[31], fprev_q[31], fprev_q};
        ctrl.mul_b = $signed({5'd0, adapt_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b1, shift: 1'b0};
      end
      afas_pkg::ST_MUL_IML: begin
        ctrl.mul_a = $signed({14'd0, r_q[19:0]});
        ctrl.mul_b = $signed({5'd0, inv_mass_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b0, shift: 1'b0};
      end
      afas_pkg::ST_MUL_IMH: begin
        ctrl.mul_a = {{10{r_q[43]}}, r_q[43:20]};
        ctrl.mul_b = $signed({5'd0, inv_mass_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b0, shift: 1'b1};
      end
      afas_pkg::ST_MUL_DTL: begin
        ctrl.mul_a = $signed({14'd0, r_q[19:0]});
        ctrl.mul_b = $signed({5'd0, time_step_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b0, shift: 1'b0};
      end
      afas_pkg::ST_MUL_DTH: begin
        ctrl.mul_a = {{10{r_q[43]}}, r_q[43:20]};
        ctrl.mul_b = $signed({5'd0, time_step_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b0, shift: 1'b1};
      end
      afas_pkg::ST_MUL_INT: begin
        ctrl.mul_a = {target_f_q[31], target_f_q[31], target_f_q}
                   - {force_q[31], force_q[31], force_q};
        ctrl.mul_b = $signed({5'd0, adapt_q});
        ctrl.pend  = '{valid: 1'b1, sub: 1'b0, shift: 1'b0};
      end
      default: ctrl = '0;
    endcase
  end

  // Accumulation of the registered product and rounding to Q16 (add one half, then floor).
  assign err_in  = {s_tdata[31], s_tdata[31:0]} - {target_f_q[31], target_f_q};
  assign addend  = pend_q.shift ? ({{4{prod_q[55]}}, prod_q} <<< 20)
                                : {{4{prod_q[55]}}, prod_q};
  assign acc_sum = pend_q.sub ? (acc_q - addend) : (acc_q + addend);
  assign acc_rnd = acc_q + 60'sd32768;

  // Two restoring division steps a cycle; the quotient shifts into the accumulator.
  always_comb begin
    rem_t = rem_q;
    quo_t = acc_q[afas_pkg::DIV_W-1:0];
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_t, quo_t[afas_pkg::DIV_W-1]};
      quo_t = {quo_t[afas_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, damping_q}) begin
        rem_t    = 21'(trial - {1'b0, damping_q});
        quo_t[0] = 1'b1;
      end else begin
        rem_t = trial[20:0];
      end
    end
  end

  // Final step: integrator, settle counter, scan pattern and the two commands.
  always_comb begin
    err_fin  = {force_q[31], force_q} - {target_f_q[31], target_f_q};
    err_mag  = err_fin[32] ? 33'(-err_fin) : 33'(err_fin);
    q_signed = $signed({2'b00, acc_q[afas_pkg::DIV_W-1:0]});
    if (neg_q) begin
      q_signed = -q_signed;
    end
    phi_sum = {{22{phi_q[31]}}, phi_q} + q_signed;
    if (damping_q == '0) begin
      phi_new = '0;
    end else if (phi_sum > 54'sd2147483647) begin
      phi_new = 32'sh7FFF_FFFF;
    end else if (phi_sum < -54'sd2147483648) begin
      phi_new = 32'sh8000_0000;
    end else begin
      phi_new = phi_sum[31:0];
    end

    cnt_new = cnt_q;
    if (err_mag < {2'b00, settle_q} && cnt_q < CNT_W'(SETTLE_TICKS + 1)) begin
      cnt_new = cnt_q + CNT_W'(1);
    end
    scanning = cnt_new > CNT_W'(SETTLE_TICKS);

    vy_raw    = '0;
    phase_new = phase_q;
    if (scanning) begin
      if (phase_q < PH_W'(UP_END)) begin
        vy_raw = $signed({27'd0, scan_spd_q});
      end else if (phase_q < PH_W'(HOLD_END)) begin
        vy_raw = '0;
      end else if (phase_q < PH_W'(DOWN_END)) begin
        vy_raw = -$signed({27'd0, scan_spd_q});
      end else begin
        vy_raw = '0;
      end
      if (phase_q == PH_W'(SCAN_PERIOD - 1)) begin
        phase_new = '0;
      end else begin
        phase_new = phase_q + PH_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= afas_pkg::ST_IDLE;
      pend_q    <= '0;
      div_cnt_q <= '0;
      m_valid_q <= 1'b0;
      phi_q     <= '0;
      fprev_q   <= '0;
      cnt_q     <= '0;
      phase_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= ctrl.pend;
      if (state_q == afas_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + afas_pkg::DIV_CNT_W'(1);
      end else begin
        div_cnt_q <= '0;
      end
      if (fin_load) begin
        m_valid_q <= 1'b1;
        phi_q     <= phi_new;
        fprev_q   <= force_q;
        cnt_q     <= cnt_new;
        phase_q   <= phase_new;
      end else if (m_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= ctrl.mul_a * ctrl.mul_b;
    if (accept) begin
      force_q <= s_tdata[31:0];
      vel_q   <= s_tdata[63:32];
      acc_q   <= {{11{err_in[32]}}, err_in, 16'd0};
    end else begin
      case (state_q)
        afas_pkg::ST_RND1, afas_pkg::ST_RND2, afas_pkg::ST_RND3: begin
          r_q   <= acc_rnd[59:16];
          acc_q <= '0;
        end
        afas_pkg::ST_DIV_INIT: begin
          neg_q <= acc_q[59];
          acc_q <= acc_q[59] ? -acc_q : acc_q;
          rem_q <= '0;
        end
        afas_pkg::ST_DIV: begin
          acc_q <= {{(60 - afas_pkg::DIV_W){1'b0}}, quo_t};
          rem_q <= rem_t;
        end
        default: begin
          if (pend_q.valid) begin
            acc_q <= acc_sum;
          end
        end
      endcase
    end
    if (fin_load) begin
      vz_out_q   <= limit_vel(r_q, vel_lim_q);
      vy_out_q   <= limit_vel(vy_raw, vel_lim_q);
      scan_out_q <= scanning;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/afas_checker.sv =====
`default_nettype none
module afas_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser
);

  logic seen_scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_scan_q <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser) begin
      seen_scan_q <= 1'b1;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // Without scanning the lateral command is zero.
  a_vy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser |-> m_tdata[35:18] == 18'd0)
    else $error("lateral command while not scanning");

  // The settle counter never clears, so scanning stays on once seen.
  a_scan_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && seen_scan_q |-> m_tuser)
    else $error("scanning dropped");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[39:36] == 4'd0)
    else $error("padding bits set");

endmodule

bind adaptive_force_admittance_step_unit afas_checker u_afas_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
